// ===== rtl/core/ihv_pkg.sv =====
`timescale 1ns / 1ps

package ihv_pkg;

  localparam logic [15:0] MIN_HEADER = 16'd20;
  localparam logic [3:0]  IP_VERSION4 = 4'd4;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [15:0] SUM_GOOD   = 16'hFFFF;

  typedef enum logic [2:0] {
    VERDICT_ICMP      = 3'd0,
    VERDICT_TCP       = 3'd1,
    VERDICT_OTHER     = 3'd2,
    VERDICT_TOO_SHORT = 3'd3,
    VERDICT_NOT_V4    = 3'd4,
    VERDICT_BAD_IHL   = 3'd5,
    VERDICT_BAD_SUM   = 3'd6
  } verdict_t;

  // Header fields and running checksum as they stand after the current byte.
  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  version_ihl;
    logic [15:0] total_length;
    logic [7:0]  protocol_byte;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ones_sum;
  } hdr_snap_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  proto_number;
    logic [5:0]  header_bytes;
    logic [15:0] payload_bytes;
    logic [31:0] source_address;
    logic [31:0] dest_address;
  } result_t;

endpackage

// ===== rtl/core/ihv_hdr_accum.sv =====
`timescale 1ns / 1ps

module ihv_hdr_accum
  import ihv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output hdr_snap_t  snap
);

  logic [15:0] byte_index_r, byte_index_nxt;
  logic [7:0]  version_ihl_r, version_ihl_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [7:0]  protocol_byte_r, protocol_byte_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [15:0] ones_sum_r, ones_sum_nxt;
  logic [7:0]  high_half_r, high_half_nxt;

  logic [5:0]  hdr_len;
  logic        in_header;
  logic [16:0] raw_sum;

  always_comb begin
    version_ihl_nxt   = version_ihl_r;
    total_length_nxt  = total_length_r;
    protocol_byte_nxt = protocol_byte_r;
    src_nxt           = src_r;
    dst_nxt           = dst_r;
    if (byte_index_r == 16'd0) begin
      version_ihl_nxt = data_byte;
    end else if (byte_index_r == 16'd2) begin
      total_length_nxt = {data_byte, total_length_r[7:0]};
    end else if (byte_index_r == 16'd3) begin
      total_length_nxt = {total_length_r[15:8], data_byte};
    end else if (byte_index_r == 16'd9) begin
      protocol_byte_nxt = data_byte;
    end else if (byte_index_r >= 16'd12 && byte_index_r <= 16'd15) begin
      src_nxt = {src_r[23:0], data_byte};
    end else if (byte_index_r >= 16'd16 && byte_index_r <= 16'd19) begin
      dst_nxt = {dst_r[23:0], data_byte};
    end

    // The IHL of byte zero already governs byte zero itself.
    hdr_len   = {version_ihl_nxt[3:0], 2'b00};
    in_header = byte_index_r < {10'd0, hdr_len};

    raw_sum       = {1'b0, ones_sum_r} + {1'b0, high_half_r, data_byte};
    high_half_nxt = high_half_r;
    ones_sum_nxt  = ones_sum_r;
    if (in_header) begin
      if (!byte_index_r[0]) begin
        high_half_nxt = data_byte;
      end else if (raw_sum[16]) begin
        ones_sum_nxt = raw_sum[15:0] + 16'd1;
      end else begin
        ones_sum_nxt = raw_sum[15:0];
      end
    end

    byte_index_nxt = (byte_index_r != COUNT_MAX) ? byte_index_r + 16'd1 : COUNT_MAX;
  end

  assign snap.byte_count    = byte_index_nxt;
  assign snap.version_ihl   = version_ihl_nxt;
  assign snap.total_length  = total_length_nxt;
  assign snap.protocol_byte = protocol_byte_nxt;
  assign snap.src_addr      = src_nxt;
  assign snap.dst_addr      = dst_nxt;
  assign snap.ones_sum      = ones_sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && last_byte)) begin
      byte_index_r    <= '0;
      version_ihl_r   <= '0;
      total_length_r  <= '0;
      protocol_byte_r <= '0;
      src_r           <= '0;
      dst_r           <= '0;
      ones_sum_r      <= '0;
      high_half_r     <= '0;
    end else if (advance) begin
      byte_index_r    <= byte_index_nxt;
      version_ihl_r   <= version_ihl_nxt;
      total_length_r  <= total_length_nxt;
      protocol_byte_r <= protocol_byte_nxt;
      src_r           <= src_nxt;
      dst_r           <= dst_nxt;
      ones_sum_r      <= ones_sum_nxt;
      high_half_r     <= high_half_nxt;
    end
  end

endmodule

// ===== rtl/core/ihv_classify.sv =====
`timescale 1ns / 1ps

module ihv_classify
  import ihv_pkg::*;
(
  input  hdr_snap_t snap,
  output result_t   result
);

  logic [5:0]  hdr_len;
  logic [15:0] hdr_len16;
  logic [15:0] payload;
  verdict_t    verdict;

  always_comb begin
    hdr_len   = {snap.version_ihl[3:0], 2'b00};
    hdr_len16 = {10'd0, hdr_len};
    payload   = (snap.total_length > hdr_len16) ? snap.total_length - hdr_len16 : 16'd0;

    if (snap.byte_count < MIN_HEADER) begin
      verdict = VERDICT_TOO_SHORT;
    end else if (snap.version_ihl[7:4] != IP_VERSION4) begin
      verdict = VERDICT_NOT_V4;
    end else if (hdr_len16 < MIN_HEADER || snap.byte_count < hdr_len16) begin
      verdict = VERDICT_BAD_IHL;
    end else if (snap.ones_sum != SUM_GOOD) begin
      verdict = VERDICT_BAD_SUM;
    end else if (snap.protocol_byte == PROTO_ICMP) begin
      verdict = VERDICT_ICMP;
    end else if (snap.protocol_byte == PROTO_TCP) begin
      verdict = VERDICT_TCP;
    end else begin
      verdict = VERDICT_OTHER;
    end

    result.verdict = verdict;
    if (verdict == VERDICT_TOO_SHORT) begin
      result.proto_number   = '0;
      result.header_bytes   = '0;
      result.payload_bytes  = '0;
      result.source_address = '0;
      result.dest_address   = '0;
    end else begin
      result.proto_number   = snap.protocol_byte;
      result.header_bytes   = hdr_len;
      result.payload_bytes  = payload;
      result.source_address = snap.src_addr;
      result.dest_address   = snap.dst_addr;
    end
  end

endmodule

// ===== rtl/core/ipv4_header_validator.sv =====
`timescale 1ns / 1ps
// IPv4 header validator.
// The input channel (in_valid/in_ready) takes one packet byte per item, in
// wire order, with in_last_byte set on the final byte. The result channel
// (out_valid/out_ready) gives one verdict item per packet: the class of the
// packet, its protocol number, header and payload lengths, and both addresses.
// A byte is first held in an input register. When it moves on, the header
// accumulator folds it into the captured fields and the checksum, and on a
// last byte the classifier result is loaded into the output register,
// from which the verdict is offered until the receiver takes it.
// Throughput is one byte per cycle, packets back to back with no gap, save for the stall below.
// If the receiver stalls, the verdict holds in the output register; bytes
// that are not last keep flowing, and the pipeline only stops when a second
// last byte reaches the accumulator while the first verdict still waits.
// Synchronous reset clears the byte count, all captured fields, the checksum
// and both valid flags; the block then waits for byte zero of a packet.

module ipv4_header_validator
  import ihv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic [7:0]  out_proto_number,
  output logic [5:0]  out_header_bytes,
  output logic [15:0] out_payload_bytes,
  output logic [31:0] out_source_address,
  output logic [31:0] out_dest_address
);

  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       s1_advance;

  hdr_snap_t  snap;
  result_t    result;
  logic       out_valid_r;
  result_t    out_r;

  // The input stage moves on unless it holds a last byte that would
  // overwrite a verdict the receiver has not taken yet.
  assign s1_advance = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  ihv_hdr_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (s1_advance),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .snap      (snap)
  );

  ihv_classify u_classify (
    .snap   (snap),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload of the output register carries no reset.
  always_ff @(posedge clk) begin
    if (s1_advance && s1_last_r) begin
      out_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = out_r.verdict;
  assign out_proto_number   = out_r.proto_number;
  assign out_header_bytes   = out_r.header_bytes;
  assign out_payload_bytes  = out_r.payload_bytes;
  assign out_source_address = out_r.source_address;
  assign out_dest_address   = out_r.dest_address;

endmodule

// ===== verif/tb_ipv4_header_validator.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the IPv4 header validator. Packets are built byte by
// byte, so their header fields and checksums are known, and are fed through
// the valid/ready input channel. A model of the header accumulator runs here
// on every byte the block accepts. On a last byte it queues the verdict item
// that the block should give. Every verdict item that leaves the block is
// compared, field by field, with the oldest queued verdict.

module tb_ipv4_header_validator;
  import ihv_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_verdict;
  logic [7:0]  out_proto_number;
  logic [5:0]  out_header_bytes;
  logic [15:0] out_payload_bytes;
  logic [31:0] out_source_address;
  logic [31:0] out_dest_address;

  ipv4_header_validator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .out_proto_number   (out_proto_number),
    .out_header_bytes   (out_header_bytes),
    .out_payload_bytes  (out_payload_bytes),
    .out_source_address (out_source_address),
    .out_dest_address   (out_dest_address)
  );

  // One directed packet. The expected verdict is only filled in, and only
  // used, where typed_exp is set; all other rows go through the header model.
  typedef struct packed {
    logic [16:0] n_bytes;
    logic [7:0]  ver_ihl;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic        fix_sum;
    logic        typed_exp;
    verdict_t    exp_verdict;
    logic [7:0]  exp_proto;
    logic [5:0]  exp_hdr;
    logic [15:0] exp_payload;
    logic [31:0] exp_src;
    logic [31:0] exp_dst;
  } dir_row_t;

  localparam int NUM_ROWS = 20;

  // Directed packets: short packets, every verdict, the extremes of the
  // captured fields, payload saturation, an IHL that runs past the end of the
  // packet, and one packet long enough to saturate the byte count.
  dir_row_t dir_rows [NUM_ROWS] = '{
    '{17'd1, 8'h45, 16'h0014, 8'h06, 32'h0a000001, 32'h0a000002, 1'b1, 1'b1,
      VERDICT_TOO_SHORT, 8'h00, 6'd0, 16'd0, 32'h0, 32'h0},
    '{17'd19, 8'h45, 16'h0014, 8'h06, 32'h0a000001, 32'h0a000002, 1'b1, 1'b1,
      VERDICT_TOO_SHORT, 8'h00, 6'd0, 16'd0, 32'h0, 32'h0},
    '{17'd20, 8'h65, 16'h0028, 8'h06, 32'h01020304, 32'h05060708, 1'b1, 1'b1,
      VERDICT_NOT_V4, 8'h06, 6'd20, 16'd20, 32'h01020304, 32'h05060708},
    '{17'd20, 8'h44, 16'h0014, 8'h11, 32'hc0a80001, 32'hc0a80002, 1'b1, 1'b1,
      VERDICT_BAD_IHL, 8'h11, 6'd16, 16'd4, 32'hc0a80001, 32'hc0a80002},
    '{17'd20, 8'h4f, 16'h0064, 8'h11, 32'hc0a80001, 32'hc0a80002, 1'b1, 1'b1,
      VERDICT_BAD_IHL, 8'h11, 6'd60, 16'd40, 32'hc0a80001, 32'hc0a80002},
    '{17'd20, 8'h45, 16'h0014, 8'h01, 32'h7f000001, 32'h7f000001, 1'b0, 1'b1,
      VERDICT_BAD_SUM, 8'h01, 6'd20, 16'd0, 32'h7f000001, 32'h7f000001},
    '{17'd28, 8'h45, 16'h001c, 8'h01, 32'h0a000001, 32'h0a0000ff, 1'b1, 1'b1,
      VERDICT_ICMP, 8'h01, 6'd20, 16'd8, 32'h0a000001, 32'h0a0000ff},
    '{17'd40, 8'h45, 16'h0028, 8'h06, 32'hac100001, 32'hac100002, 1'b1, 1'b1,
      VERDICT_TCP, 8'h06, 6'd20, 16'd20, 32'hac100001, 32'hac100002},
    '{17'd30, 8'h45, 16'h001e, 8'h11, 32'h08080808, 32'h08080404, 1'b1, 1'b1,
      VERDICT_OTHER, 8'h11, 6'd20, 16'd10, 32'h08080808, 32'h08080404},
    '{17'd20, 8'h45, 16'h0014, 8'h00, 32'h00000000, 32'h00000000, 1'b1, 1'b1,
      VERDICT_OTHER, 8'h00, 6'd20, 16'd0, 32'h0, 32'h0},
    '{17'd64, 8'h4f, 16'hffff, 8'hff, 32'hffffffff, 32'hffffffff, 1'b1, 1'b1,
      VERDICT_OTHER, 8'hff, 6'd60, 16'hffc3, 32'hffffffff, 32'hffffffff},
    '{17'd24, 8'h45, 16'h000a, 8'h06, 32'h11223344, 32'h55667788, 1'b1, 1'b1,
      VERDICT_TCP, 8'h06, 6'd20, 16'd0, 32'h11223344, 32'h55667788},
    '{17'd20, 8'hff, 16'h1234, 8'h06, 32'ha5a5a5a5, 32'h5a5a5a5a, 1'b1, 1'b1,
      VERDICT_NOT_V4, 8'h06, 6'd60, 16'h11f8, 32'ha5a5a5a5, 32'h5a5a5a5a},
    '{17'd20, 8'h00, 16'h0014, 8'h06, 32'h01010101, 32'h02020202, 1'b0, 1'b1,
      VERDICT_NOT_V4, 8'h06, 6'd0, 16'd20, 32'h01010101, 32'h02020202},
    '{17'd20, 8'h40, 16'h0014, 8'h06, 32'h01010101, 32'h02020202, 1'b1, 1'b1,
      VERDICT_BAD_IHL, 8'h06, 6'd0, 16'd20, 32'h01010101, 32'h02020202},
    '{17'd65540, 8'h45, 16'hffff, 8'h06, 32'h0a0a0a0a, 32'h0b0b0b0b, 1'b1, 1'b0,
      VERDICT_ICMP, 8'h00, 6'd0, 16'd0, 32'h0, 32'h0},
    '{17'd60, 8'h4f, 16'h003c, 8'h06, 32'h12345678, 32'h9abcdef0, 1'b1, 1'b0,
      VERDICT_ICMP, 8'h00, 6'd0, 16'd0, 32'h0, 32'h0},
    '{17'd59, 8'h4f, 16'h003c, 8'h01, 32'h12345678, 32'h9abcdef0, 1'b1, 1'b1,
      VERDICT_BAD_IHL, 8'h01, 6'd60, 16'd0, 32'h12345678, 32'h9abcdef0},
    '{17'd21, 8'h46, 16'h0030, 8'h06, 32'h0a000001, 32'h0a000002, 1'b1, 1'b1,
      VERDICT_BAD_IHL, 8'h06, 6'd24, 16'd24, 32'h0a000001, 32'h0a000002},
    '{17'd52, 8'h48, 16'h0034, 8'h02, 32'h0a000003, 32'h0a000004, 1'b1, 1'b0,
      VERDICT_ICMP, 8'h00, 6'd0, 16'd0, 32'h0, 32'h0}
  };

  // Header model state, as it stands after the last accepted byte.
  logic [15:0] seen_count    = '0;
  logic [7:0]  cap_ver_ihl   = '0;
  logic [15:0] cap_total_len = '0;
  logic [7:0]  cap_proto     = '0;
  logic [31:0] cap_src       = '0;
  logic [31:0] cap_dst       = '0;
  logic [15:0] hdr_sum       = '0;
  logic [7:0]  word_hi       = '0;

  result_t     verdicts_due[$];
  logic [7:0]  pkt_bytes[$];
  int          bytes_sent    = 0;
  int          mismatches    = 0;

  // Idle rates in percent for the sender and the receiver. A nonzero
  // rx_hold_cycles makes the receiver hold off once; then the bench clears it.
  int          tx_idle_pct   = 33;
  int          rx_idle_pct   = 33;
  int          rx_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Folds one accepted byte into the header model. On a last byte the verdict
  // item is queued (or the typed one, for directed rows that carry it) and the
  // model clears itself for the next packet.
  task automatic ip_track_byte(input logic [7:0] b, input logic last_b,
                               input logic typed_exp, input result_t typed_res);
    logic [15:0] pos;
    logic [5:0]  hdr_len;
    logic [16:0] acc;
    logic [15:0] payload;
    result_t     r;
    pos = seen_count;
    if (pos == 16'd0) cap_ver_ihl = b;
    else if (pos == 16'd2) cap_total_len[15:8] = b;
    else if (pos == 16'd3) cap_total_len[7:0] = b;
    else if (pos == 16'd9) cap_proto = b;
    else if (pos >= 16'd12 && pos <= 16'd15) cap_src = {cap_src[23:0], b};
    else if (pos >= 16'd16 && pos <= 16'd19) cap_dst = {cap_dst[23:0], b};

    // Only the IHL*4 header bytes enter the checksum, as 16-bit words with
    // the end-around carry folded back in.
    hdr_len = {cap_ver_ihl[3:0], 2'b00};
    if (pos < hdr_len) begin
      if (!pos[0]) begin
        word_hi = b;
      end else begin
        acc = hdr_sum + {word_hi, b};
        hdr_sum = acc[15:0] + acc[16];
      end
    end

    // The count stops at its maximum; later bytes are still taken.
    if (pos != COUNT_MAX) seen_count = pos + 16'd1;

    if (last_b) begin
      payload = (cap_total_len > hdr_len) ? cap_total_len - hdr_len : 16'd0;
      r = '0;
      if (seen_count < MIN_HEADER) begin
        // A too short packet reports nothing but its verdict.
        r.verdict = VERDICT_TOO_SHORT;
      end else begin
        if (cap_ver_ihl[7:4] != IP_VERSION4) r.verdict = VERDICT_NOT_V4;
        else if (hdr_len < MIN_HEADER || seen_count < hdr_len) r.verdict = VERDICT_BAD_IHL;
        else if (hdr_sum != SUM_GOOD) r.verdict = VERDICT_BAD_SUM;
        else if (cap_proto == PROTO_ICMP) r.verdict = VERDICT_ICMP;
        else if (cap_proto == PROTO_TCP) r.verdict = VERDICT_TCP;
        else r.verdict = VERDICT_OTHER;
        r.proto_number   = cap_proto;
        r.header_bytes   = hdr_len;
        r.payload_bytes  = payload;
        r.source_address = cap_src;
        r.dest_address   = cap_dst;
      end
      verdicts_due.push_back(typed_exp ? typed_res : r);
      seen_count    = '0;
      cap_ver_ihl   = '0;
      cap_total_len = '0;
      cap_proto     = '0;
      cap_src       = '0;
      cap_dst       = '0;
      hdr_sum       = '0;
      word_hi       = '0;
    end
  endtask

  // Lays out a packet of n bytes in pkt_bytes. The fixed header fields go at
  // their offsets, everything else is random. The checksum field is set so
  // that the header sums to all ones, or, without fix, to a value one off.
  task automatic build_packet(input logic [16:0] n, input logic [7:0] vi,
                              input logic [15:0] tl, input logic [7:0] pr,
                              input logic [31:0] sa, input logic [31:0] da,
                              input logic fix);
    logic [7:0]  hb [0:59];
    logic [16:0] sum;
    logic [15:0] csum;
    int          hlen;
    for (int k = 0; k < 60; k++) hb[k] = 8'($urandom_range(255));
    hb[0]  = vi;
    hb[2]  = tl[15:8];
    hb[3]  = tl[7:0];
    hb[9]  = pr;
    hb[10] = 8'h00;
    hb[11] = 8'h00;
    {hb[12], hb[13], hb[14], hb[15]} = sa;
    {hb[16], hb[17], hb[18], hb[19]} = da;
    hlen = vi[3:0] * 4;
    sum = '0;
    for (int k = 0; k < hlen; k += 2) begin
      sum = sum[15:0] + {hb[k], hb[k + 1]};
      sum = sum[15:0] + sum[16];
    end
    csum = fix ? ~sum[15:0] : (~sum[15:0] ^ 16'h0001);
    hb[10] = csum[15:8];
    hb[11] = csum[7:0];
    pkt_bytes.delete();
    for (int k = 0; k < n; k++) begin
      pkt_bytes.push_back((k < 60) ? hb[k] : 8'($urandom_range(255)));
    end
  endtask

  // Offers the bytes of pkt_bytes one item at a time, with random gaps, and
  // runs the header model on each byte as the block accepts it. Valid is left
  // high after the last byte; the next caller decides what follows.
  task automatic send_packet(input logic typed_exp, input result_t typed_res);
    int last_idx;
    last_idx = pkt_bytes.size() - 1;
    for (int i = 0; i <= last_idx; i++) begin
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_data_byte <= pkt_bytes[i];
      in_last_byte <= (i == last_idx);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      ip_track_byte(pkt_bytes[i], i == last_idx, typed_exp, typed_res);
      bytes_sent++;
    end
  endtask

  // The sender goes quiet until every queued verdict has come out.
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random back-pressure, or a long hold when the sender asks.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Every verdict item taken from the block must match the oldest queued one.
  always @(posedge clk) begin : check_verdicts
    result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict item with none expected: verdict %0d", out_verdict);
        mismatches++;
      end else begin
        due = verdicts_due.pop_front();
        if (out_verdict !== due.verdict) begin
          $error("verdict: expected %0d, actual %0d", due.verdict, out_verdict);
          mismatches++;
        end
        if (out_proto_number !== due.proto_number) begin
          $error("proto_number: expected %0d, actual %0d", due.proto_number,
                 out_proto_number);
          mismatches++;
        end
        if (out_header_bytes !== due.header_bytes) begin
          $error("header_bytes: expected %0d, actual %0d", due.header_bytes,
                 out_header_bytes);
          mismatches++;
        end
        if (out_payload_bytes !== due.payload_bytes) begin
          $error("payload_bytes: expected %0d, actual %0d", due.payload_bytes,
                 out_payload_bytes);
          mismatches++;
        end
        if (out_source_address !== due.source_address) begin
          $error("source_address: expected %h, actual %h", due.source_address,
                 out_source_address);
          mismatches++;
        end
        if (out_dest_address !== due.dest_address) begin
          $error("dest_address: expected %h, actual %h", due.dest_address,
                 out_dest_address);
          mismatches++;
        end
      end
    end
  end

  initial begin
    dir_row_t    row;
    result_t     want;
    logic [7:0]  vi;
    logic [7:0]  pr;
    logic [15:0] tl;
    logic [16:0] n;
    logic        fix;
    int          ihl;
    int          sel;
    int          pkts;
    int          rand_start;
    int          wait_cycles;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed packets, walked row by row.
    for (int r_i = 0; r_i < NUM_ROWS; r_i++) begin
      row = dir_rows[r_i];
      build_packet(row.n_bytes, row.ver_ihl, row.total_len, row.proto, row.src,
                   row.dst, row.fix_sum);
      want = '{row.exp_verdict, row.exp_proto, row.exp_hdr, row.exp_payload,
               row.exp_src, row.exp_dst};
      send_packet(row.typed_exp, want);
    end
    wait_for_verdicts();

    // Back-pressure: the receiver holds off while one-byte packets keep
    // coming, so verdicts pile up and the block has to stop taking bytes.
    rx_hold_cycles = 300;
    for (int k = 0; k < 40; k++) begin
      build_packet(17'd1, 8'($urandom_range(255)), 16'h0, 8'h0, 32'h0, 32'h0, 1'b1);
      send_packet(1'b0, '0);
    end
    wait_for_verdicts();

    // Random packets. Most are well formed with random content; the rest have
    // a bad checksum, a wrong version, a bad IHL, too few bytes, or are noise.
    pkts = 0;
    rand_start = bytes_sent;
    while ((bytes_sent - rand_start) < 900 || pkts < 48) begin
      // A run of packets with neither side idling.
      if (pkts == 12) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (pkts == 24) begin
        tx_idle_pct = 33;
        rx_idle_pct = 33;
      end
      sel = $urandom_range(99);
      ihl = ($urandom_range(3) == 0) ? $urandom_range(6, 15) : 5;
      vi  = {IP_VERSION4, 4'(ihl)};
      n   = 17'(ihl * 4 + $urandom_range(0, 16));
      case ($urandom_range(3))
        0:       pr = PROTO_ICMP;
        1:       pr = PROTO_TCP;
        default: pr = 8'($urandom_range(255));
      endcase
      fix = 1'b1;
      if (sel < 60) begin
        fix = 1'b1;
      end else if (sel < 70) begin
        fix = 1'b0;
      end else if (sel < 77) begin
        vi[7:4] = IP_VERSION4 ^ 4'($urandom_range(1, 15));
        fix = 1'($urandom_range(1));
      end else if (sel < 84) begin
        // Either an IHL under five words or a header cut off by the last byte.
        if ($urandom_range(1) == 0) begin
          vi[3:0] = 4'($urandom_range(4));
        end else begin
          vi[3:0] = 4'hf;
          n = 17'($urandom_range(20, 59));
        end
      end else if (sel < 92) begin
        n = 17'($urandom_range(1, 19));
      end else begin
        vi  = 8'($urandom_range(255));
        pr  = 8'($urandom_range(255));
        n   = 17'($urandom_range(1, 40));
        fix = 1'($urandom_range(1));
      end
      case ($urandom_range(3))
        0, 1:    tl = n[15:0];
        2:       tl = 16'($urandom_range(65535));
        default: tl = 16'($urandom_range(80));
      endcase
      build_packet(n, vi, tl, pr, $urandom, $urandom, fix);
      send_packet(1'b0, '0);
      pkts++;
    end
    in_valid <= 1'b0;

    // Let the last verdicts drain, then watch a little longer for strays.
    wait_cycles = 0;
    while (verdicts_due.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      $error("%0d verdict items never came out", verdicts_due.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("tb_ipv4_header_validator passed");
    end else begin
      $display("tb_ipv4_header_validator failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("tb_ipv4_header_validator failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ihv_pkg.sv
rtl/core/ihv_hdr_accum.sv
rtl/core/ihv_classify.sv
rtl/core/ipv4_header_validator.sv
verif/tb_ipv4_header_validator.sv
